// File: rtl/core/line_bounded_pattern_counter_top_defines.svh
// assertion macros for the line bounded pattern counter
`ifndef LINE_BOUNDED_PATTERN_COUNTER_TOP_DEFINES_SVH
`define LINE_BOUNDED_PATTERN_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LBPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbpc check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define LBPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbpc check failed: next-cycle implication");

`endif

// File: rtl/core/lbpc_pkg.sv
`default_nettype none

package lbpc_pkg;

   // largest pattern the window can hold
   localparam int MAX_PATTERN_DEF = 16;
   localparam int PATTERN_BYTES   = 16;

   localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
   localparam logic [7:0]  NUL_BYTE     = 8'h00;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PATTERN_FIRST  = 2'd0,
      CSR_PATTERN_LAST   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   // pattern bytes, byte 0 in the lowest bits
   typedef logic [PATTERN_BYTES-1:0][7:0] pattern_type;

   // window control sent to every cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/lbpc_req_if.sv
`default_nettype none

interface lbpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lbpc_rsp_if.sv
`default_nettype none

interface lbpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_end;
   logic [31:0] match_count;
   logic        found;
   logic        file_done;

   modport source (
      output valid, output match_end, output match_count, output found,
      output file_done, input ready
   );
   modport sink (
      input valid, input match_end, input match_count, input found,
      input file_done, output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/lbpc_csr_if.sv
`default_nettype none

interface lbpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lbpc_cell.sv
`default_nettype none

// one window position: holds a byte and its valid flag, compares the
// byte arriving from its left neighbor against the aligned pattern byte
module lbpc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lbpc_pkg::cell_ctrl_type ctrl,
   input  wire logic [7:0]             byte_in,
   input  wire logic                   valid_in,
   input  wire lbpc_pkg::pattern_type  pattern,
   input  wire logic [4:0]             pattern_length,
   output logic [7:0]                  byte_out,
   output logic                        valid_out,
   output logic                        match_ok
);

   logic [7:0] byte_ff;
   logic       valid_ff;
   logic       slot_valid_in;
   logic [4:0] pat_index;
   logic       in_use;

   // pattern byte that lines up with this position after the shift
   assign in_use    = pattern_length > 5'(CELL_INDEX);
   assign pat_index = pattern_length - 5'(CELL_INDEX) - 5'd1;
   assign match_ok  = !in_use ||
                      (valid_in && (byte_in == pattern[pat_index[3:0]]));

   // valid flag: cleared by newline, nul or end of file
   always_comb begin
      slot_valid_in = valid_ff;
      if (ctrl.clear) begin
         slot_valid_in = 1'b0;
      end else if (ctrl.shift) begin
         slot_valid_in = valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= slot_valid_in;
      end
   end

   // byte payload moves right on every shift
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/line_bounded_pattern_counter_top.sv
// a result is registered and shown in the cycle after its request is accepted
// throughput: one request per cycle while the receiver takes each result; the window is a row of cells that
// shift and compare in the same cycle, counted in one 32-bit adder
// reset: pattern registers, window, nul skip flag and count clear at once
// the count and window also clear after a request marked end of file
`default_nettype none
`include "line_bounded_pattern_counter_top_defines.svh"

module line_bounded_pattern_counter_top #(
   parameter int MAX_PATTERN = lbpc_pkg::MAX_PATTERN_DEF
) (
   input wire logic clock,
   input wire logic reset,
   lbpc_req_if.sink   req_chan,
   lbpc_rsp_if.source rsp_chan,
   lbpc_csr_if.sink   csr_chan
);

   // configuration registers
   logic [63:0] pat_first_ff;
   logic [63:0] pat_last_ff;
   logic [4:0]  pat_length_ff;
   lbpc_pkg::pattern_type pattern;

   assign csr_chan.ready = 1'b1;
   assign pattern = {pat_last_ff, pat_first_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_first_ff  <= '0;
         pat_last_ff   <= '0;
         pat_length_ff <= '0;
      end else if (csr_chan.valid) begin
         case (lbpc_pkg::csr_index_type'(csr_chan.index))
            lbpc_pkg::CSR_PATTERN_FIRST:  pat_first_ff  <= csr_chan.data;
            lbpc_pkg::CSR_PATTERN_LAST:   pat_last_ff   <= csr_chan.data;
            lbpc_pkg::CSR_PATTERN_LENGTH: pat_length_ff <= csr_chan.data[4:0];
            default: begin
            end
         endcase
      end
   end

   // request handshake with a registered response stage
   logic rsp_valid_ff;
   logic req_accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // byte classification
   logic is_newline;
   logic is_nul;
   logic skip_ff;
   logic skip_in;
   lbpc_pkg::cell_ctrl_type ctrl;

   assign is_newline = req_chan.data_byte == lbpc_pkg::NEWLINE_BYTE;
   assign is_nul     = req_chan.data_byte == lbpc_pkg::NUL_BYTE;
   assign ctrl.shift = req_accept && !is_newline && !is_nul && !skip_ff;
   assign ctrl.clear = req_accept && (is_newline || is_nul || req_chan.end_of_file);

   // nul skip flag, released by newline or end of file
   always_comb begin
      skip_in = skip_ff;
      if (req_accept) begin
         if (is_newline || req_chan.end_of_file) begin
            skip_in = 1'b0;
         end else if (is_nul) begin
            skip_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
      end else begin
         skip_ff <= skip_in;
      end
   end

   // window: row of cells, cell 0 takes the new byte
   logic [MAX_PATTERN-1:0][7:0] win_byte;
   logic [MAX_PATTERN-1:0]      win_valid;
   logic [MAX_PATTERN-1:0]      cell_ok;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [7:0] byte_left;
      logic       valid_left;

      if (k == 0) begin : g_head
         assign byte_left  = req_chan.data_byte;
         assign valid_left = 1'b1;
      end else begin : g_body
         assign byte_left  = win_byte[k-1];
         assign valid_left = win_valid[k-1];
      end

      lbpc_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .byte_in        (byte_left),
         .valid_in       (valid_left),
         .pattern        (pattern),
         .pattern_length (pat_length_ff),
         .byte_out       (win_byte[k]),
         .valid_out      (win_valid[k]),
         .match_ok       (cell_ok[k])
      );
   end

   // match ends here when every cell in use agrees
   logic hit;

   assign hit = ctrl.shift && (pat_length_ff != 5'd0) &&
                (pat_length_ff <= 5'(MAX_PATTERN)) && (&cell_ok);

   // occurrence count, saturating
   logic [31:0] count_ff;
   logic [31:0] count_step;
   logic [31:0] count_in;

   always_comb begin
      count_step = count_ff;
      if (hit && (count_ff != lbpc_pkg::COUNT_MAX)) begin
         count_step = count_ff + 32'd1;
      end
      count_in = count_ff;
      if (req_accept) begin
         count_in = req_chan.end_of_file ? 32'd0 : count_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response register
   logic        match_end_ff;
   logic [31:0] match_count_ff;
   logic        found_ff;
   logic        file_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         match_end_ff   <= hit;
         match_count_ff <= count_step;
         found_ff       <= count_step != 32'd0;
         file_done_ff   <= req_chan.end_of_file;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_end   = match_end_ff;
   assign rsp_chan.match_count = match_count_ff;
   assign rsp_chan.found       = found_ff;
   assign rsp_chan.file_done   = file_done_ff;

   // checks
   `LBPC_ASSERT_NOW(a_match_implies_found, clock, reset,
      rsp_valid_ff && match_end_ff, found_ff)
   `LBPC_ASSERT_NOW(a_found_tracks_count, clock, reset,
      rsp_valid_ff, found_ff == (match_count_ff != 32'd0))
   `LBPC_ASSERT_NEXT(a_eof_clears_count, clock, reset,
      req_accept && req_chan.end_of_file, count_ff == 32'd0 && !skip_ff)
   `LBPC_ASSERT_NEXT(a_newline_clears_window, clock, reset,
      req_accept && is_newline, win_valid == '0)

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_BYTES  = lbpc_pkg::MAX_PATTERN_DEF;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_BYTES   = 290;
   localparam int RANDOM_PHASES = 6;
   localparam int EOF_ODDS      = 120;

   typedef struct packed {
      logic        match_end;
      logic [31:0] match_count;
      logic        found;
      logic        file_done;
   } scan_result_type;

   typedef enum logic {
      ROW_BYTE,
      ROW_CSR
   } row_kind_type;

   // one line of the directed table: a register write or a text byte,
   // with the result typed in where pinned is set
   typedef struct packed {
      row_kind_type            kind;
      lbpc_pkg::csr_index_type csr_index;
      logic [63:0]             csr_data;
      logic [7:0]              data_byte;
      logic                    end_of_file;
      logic                    pinned;
      logic                    match_end;
      logic [31:0]             match_count;
      logic                    found;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 36;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // reset state, zero length never matches
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h0A, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      // two byte pattern 7f 7f, overlaps, newline, nul skip, end of file
      '{ROW_CSR,  lbpc_pkg::CSR_PATTERN_FIRST, 64'h0000_0000_0000_7F7F, 8'h00, 1'b0,
        1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_CSR,  lbpc_pkg::CSR_PATTERN_LAST, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_CSR,  lbpc_pkg::CSR_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,
        1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h7F, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h7F, 1'b0, 1'b1, 1'b1, 32'd1, 1'b1},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h7F, 1'b0, 1'b1, 1'b1, 32'd2, 1'b1},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h0A, 1'b0, 1'b1, 1'b0, 32'd2, 1'b1},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h7F, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h00, 1'b0, 1'b1, 1'b0, 32'd2, 1'b1},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h7F, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h0A, 1'b0, 1'b1, 1'b0, 32'd2, 1'b1},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h7F, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'h7F, 1'b1, 1'b1, 1'b1, 32'd3, 1'b1},
      // full sixteen byte pattern of all ones
      '{ROW_CSR,  lbpc_pkg::CSR_PATTERN_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0,
        1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_CSR,  lbpc_pkg::CSR_PATTERN_LAST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0,
        1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_CSR,  lbpc_pkg::CSR_PATTERN_LENGTH, 64'd16, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,
        1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b1, 32'd1, 1'b1},
      // length above the window never matches
      '{ROW_CSR,  lbpc_pkg::CSR_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,
        1'b0},
      '{ROW_BYTE, lbpc_pkg::CSR_UNUSED, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b0, 32'd1, 1'b1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbpc_req_if req_bus ();
   lbpc_rsp_if rsp_bus ();
   lbpc_csr_if csr_bus ();

   line_bounded_pattern_counter_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int bytes_sent    = 0;
   int results_seen  = 0;
   int error_count   = 0;
   int stall_cycles  = 0;

   // typed-in result riding along with the request being offered
   logic            pin_on = 1'b0;
   scan_result_type pin_result = '0;

   scan_result_type pending_results [$];

   // scanner copy: pattern registers and line window
   lbpc_pkg::pattern_type        pattern_q;
   logic [4:0]                   pattern_len_q;
   logic [WINDOW_BYTES-1:0][7:0] window_q;
   logic [4:0]                   fill_q;
   logic                         skip_q;
   logic [31:0]                  count_q;

   // advance the scanner copy by one text byte and form its result
   function automatic scan_result_type scan_byte(input logic [7:0] value,
                                                 input logic eof);
      scan_result_type res;
      logic            hit;
      hit = 1'b0;
      if (value == lbpc_pkg::NEWLINE_BYTE) begin
         window_q = '0;
         fill_q   = '0;
         skip_q   = 1'b0;
      end else if (value == lbpc_pkg::NUL_BYTE) begin
         window_q = '0;
         fill_q   = '0;
         skip_q   = 1'b1;
      end else if (!skip_q) begin
         window_q = {window_q[WINDOW_BYTES-2:0], value};
         if (fill_q < WINDOW_BYTES) fill_q++;
         // oldest window byte lines up with pattern byte 0
         if (pattern_len_q != 0 && pattern_len_q <= WINDOW_BYTES &&
             fill_q >= pattern_len_q) begin
            hit = 1'b1;
            for (int i = 0; i < pattern_len_q; i++)
               if (window_q[pattern_len_q - 1 - i] != pattern_q[i]) hit = 1'b0;
         end
         if (hit && count_q != lbpc_pkg::COUNT_MAX) count_q++;
      end
      res.match_end   = hit;
      res.match_count = count_q;
      res.found       = (count_q != 0);
      res.file_done   = eof;
      if (eof) begin
         count_q  = '0;
         window_q = '0;
         fill_q   = '0;
         skip_q   = 1'b0;
      end
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // receiver side stalls
   always @(posedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);

   // track writes and requests, check every result against the oldest expectation
   always @(posedge clock) begin
      scan_result_type predicted;
      scan_result_type seen;
      scan_result_type wanted;
      if (reset) begin
         pattern_q     = '0;
         pattern_len_q = '0;
         window_q      = '0;
         fill_q        = '0;
         skip_q        = 1'b0;
         count_q       = '0;
         pending_results.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               lbpc_pkg::CSR_PATTERN_FIRST:  pattern_q[7:0]  = csr_bus.data;
               lbpc_pkg::CSR_PATTERN_LAST:   pattern_q[15:8] = csr_bus.data;
               lbpc_pkg::CSR_PATTERN_LENGTH: pattern_len_q   = csr_bus.data[4:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = scan_byte(req_bus.data_byte, req_bus.end_of_file);
            pending_results = {pending_results, (pin_on ? pin_result : predicted)};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            seen = '{rsp_bus.match_end, rsp_bus.match_count, rsp_bus.found, rsp_bus.file_done};
            if (pending_results.size() == 0) begin
               $error("result with no request waiting");
               error_count++;
            end else begin
               wanted = pending_results.pop_front();
               check_field("match_end", 32'(wanted.match_end), 32'(seen.match_end));
               check_field("match_count", wanted.match_count, seen.match_count);
               check_field("found", 32'(wanted.found), 32'(seen.found));
               check_field("file_done", 32'(wanted.file_done), 32'(seen.file_done));
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // offer one text byte, with random sender idling in front of it
   task automatic send_byte(input logic [7:0] value, input logic eof, input logic pin,
                            input scan_result_type pinned_result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= value;
      req_bus.end_of_file <= eof;
      pin_on              <= pin;
      pin_result          <= pinned_result;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic write_csr(input lbpc_pkg::csr_index_type index, input logic [63:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // let every outstanding result come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_seen != bytes_sent);
      repeat (2) @(posedge clock);
   endtask

   // random text: pattern copies, some broken, mixed with noise
   task automatic send_text(input lbpc_pkg::pattern_type pat, input int used);
      int         count;
      int         pick;
      int         cut;
      logic [7:0] value;
      count = 0;
      while (count < PHASE_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            cut = ($urandom_range(3) == 0) ? $urandom_range(used - 1) : used;
            for (int i = 0; i < used; i++) begin
               value = pat[i];
               if (i == cut) begin
                  case ($urandom_range(2))
                     0:       value = 8'($urandom_range(255));
                     1:       value = lbpc_pkg::NEWLINE_BYTE;
                     default: value = lbpc_pkg::NUL_BYTE;
                  endcase
               end
               send_byte(value, ($urandom_range(EOF_ODDS - 1) == 0), 1'b0, '0);
               count++;
            end
         end else begin
            if (pick < 75)
               value = pat[$urandom_range(used - 1)];
            else if (pick < 90)
               value = 8'($urandom_range(255));
            else if (pick < 96)
               value = lbpc_pkg::NEWLINE_BYTE;
            else
               value = lbpc_pkg::NUL_BYTE;
            send_byte(value, ($urandom_range(EOF_ODDS - 1) == 0), 1'b0, '0);
            count++;
         end
      end
   endtask

   initial begin
      scan_result_type       pinned;
      lbpc_pkg::pattern_type pattern;
      int                    length;
      int                    used;

      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.end_of_file = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = lbpc_pkg::CSR_PATTERN_FIRST;
      csr_bus.data        = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      send_idle_pct = 26;
      rsp_idle_pct  = 56;
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_CSR) begin
            wait_drained();
            write_csr(DIRECTED_ROWS[r].csr_index, DIRECTED_ROWS[r].csr_data);
         end else begin
            pinned = '{DIRECTED_ROWS[r].match_end, DIRECTED_ROWS[r].match_count,
                       DIRECTED_ROWS[r].found, DIRECTED_ROWS[r].end_of_file};
            send_byte(DIRECTED_ROWS[r].data_byte, DIRECTED_ROWS[r].end_of_file,
                      DIRECTED_ROWS[r].pinned, pinned);
         end
      end

      // random phases, each with its own pattern; the idling profile changes every two phases
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase / 2)
            0: begin
               send_idle_pct = 26;
               rsp_idle_pct  = 56;
            end
            1: begin
               send_idle_pct = 56;
               rsp_idle_pct  = 26;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         case (phase)
            0:       length = 1;
            1:       length = WINDOW_BYTES;
            2:       length = $urandom_range(6, 2);
            3:       length = $urandom_range(31, WINDOW_BYTES + 1);
            4:       length = $urandom_range(8, 3);
            default: length = $urandom_range(WINDOW_BYTES, 1);
         endcase
         used = (length > WINDOW_BYTES) ? WINDOW_BYTES : length;
         pattern = {$urandom, $urandom, $urandom, $urandom};
         // repeated bytes give overlapping matches; no newline or nul in use
         for (int i = 0; i < used; i++) begin
            if (i > 0 && $urandom_range(2) == 0) pattern[i] = pattern[i - 1];
            while (pattern[i] == lbpc_pkg::NUL_BYTE || pattern[i] == lbpc_pkg::NEWLINE_BYTE)
               pattern[i] = 8'($urandom_range(255, 1));
         end
         // a nul inside the pattern can never match
         if (phase == 4) pattern[$urandom_range(used - 1)] = lbpc_pkg::NUL_BYTE;
         write_csr(lbpc_pkg::CSR_PATTERN_FIRST, pattern[7:0]);
         write_csr(lbpc_pkg::CSR_PATTERN_LAST, pattern[15:8]);
         write_csr(lbpc_pkg::CSR_PATTERN_LENGTH, 64'(length));
         if (phase == 3) write_csr(lbpc_pkg::CSR_UNUSED, {$urandom, $urandom});
         send_text(pattern, used);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
